// ===== rtl/debounced_buttons_to_note_events_macros.svh =====
// Assertion macros shared by the checker.
`ifndef DEBOUNCED_BUTTONS_TO_NOTE_EVENTS_MACROS_SVH
`define DEBOUNCED_BUTTONS_TO_NOTE_EVENTS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DBNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DBNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dbne_pkg.sv =====
package dbne_pkg;

  localparam int unsigned DebounceDepthDef = 4;

  localparam int unsigned ButtonW  = 14;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned CableW   = 4;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned NumChan  = 8;
  localparam int unsigned ChanIdxW = 3;

  // Result slots of one tick, emitted lowest first
  localparam int unsigned SlotW      = 11;
  localparam int unsigned SLOT_REPORT = 0;
  localparam int unsigned SLOT_CHAN0  = 1;
  localparam int unsigned SLOT_BEATS  = 9;
  localparam int unsigned SLOT_NAME   = 10;

  // Button positions in the pressed vector
  localparam int unsigned BIT_SOLO  = 8;
  localparam int unsigned BIT_MUTE  = 9;
  localparam int unsigned BIT_REC   = 10;
  localparam int unsigned BIT_VPOT  = 11;
  localparam int unsigned BIT_BEATS = 12;
  localparam int unsigned BIT_NAME  = 13;

  // Channel modes
  localparam logic [ModeW-1:0] MODE_SELECT = 3'd0;
  localparam logic [ModeW-1:0] MODE_SOLO   = 3'd1;
  localparam logic [ModeW-1:0] MODE_MUTE   = 3'd2;
  localparam logic [ModeW-1:0] MODE_REC    = 3'd3;
  localparam logic [ModeW-1:0] MODE_VPOT   = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_CABLE       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SELECT_BASE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SOLO_BASE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MUTE_BASE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REC_BASE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VPOT_BASE   = 3'd5;

  // Configuration reset values
  localparam logic [CableW-1:0] CABLE_RST       = 4'd0;
  localparam logic [NoteW-1:0]  SELECT_BASE_RST = 7'd24;
  localparam logic [NoteW-1:0]  SOLO_BASE_RST   = 7'd8;
  localparam logic [NoteW-1:0]  MUTE_BASE_RST   = 7'd16;
  localparam logic [NoteW-1:0]  REC_BASE_RST    = 7'd0;
  localparam logic [NoteW-1:0]  VPOT_BASE_RST   = 7'd32;

  // Fixed notes and velocities
  localparam logic [NoteW-1:0] NOTE_BEATS = 7'h35;
  localparam logic [NoteW-1:0] NOTE_NAME  = 7'h34;
  localparam logic [VelW-1:0]  VEL_ON     = 7'h7f;
  localparam logic [VelW-1:0]  VEL_OFF    = 7'h00;

  // Work record for one stable change: which results are due and their data
  typedef struct packed {
    logic [SlotW-1:0]   slots;
    logic [ButtonW-1:0] buttons;
    logic [ModeW-1:0]   mode;
    logic [NoteW-1:0]   base;
    logic [CableW-1:0]  cable;
  } rec_t;

endpackage

// ===== rtl/dbne_front.sv =====
module dbne_front #(
  parameter int unsigned DEBOUNCE_DEPTH = dbne_pkg::DebounceDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dbne_pkg::ButtonW-1:0]  in_pressed_vector,
  input  logic                          cfg_wr_en,
  input  logic [dbne_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dbne_pkg::CfgDataW-1:0] cfg_data,
  output dbne_pkg::rec_t                rec,
  output logic                          rec_valid,
  input  logic                          rec_take
);

  logic [dbne_pkg::ButtonW-1:0] hist_r [DEBOUNCE_DEPTH];
  logic [dbne_pkg::ButtonW-1:0] stable_r;
  logic [dbne_pkg::ModeW-1:0]   mode_r, mode_nxt;
  logic [dbne_pkg::CableW-1:0]  cable_r;
  logic [dbne_pkg::NoteW-1:0]   base_r [5];
  dbne_pkg::rec_t               rec_r, rec_nxt;
  logic                         rec_valid_r, rec_valid_nxt;

  logic                         in_acc;
  logic                         stable;
  logic [dbne_pkg::ButtonW-1:0] now, delta;
  logic                         mode_hit;
  logic [dbne_pkg::ModeW-1:0]   target;
  logic [dbne_pkg::NoteW-1:0]   base_sel;
  logic [dbne_pkg::SlotW-1:0]   slots;

  assign now      = in_pressed_vector;
  assign in_stall = rec_valid_r && !rec_take;
  assign in_acc   = in_valid && !in_stall;

  // Stable only when every stored sample matches the new one
  always_comb begin
    stable = 1'b1;
    for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
      if (hist_r[i] != now) stable = 1'b0;
    end
  end

  assign delta    = stable_r ^ now;
  assign mode_hit = stable && (|delta[dbne_pkg::BIT_VPOT:dbne_pkg::BIT_SOLO])
                    && (|now[dbne_pkg::BIT_VPOT:dbne_pkg::BIT_SOLO]);

  // Pick the held mode button by priority, toggle back to select on repeat
  always_comb begin
    if (now[dbne_pkg::BIT_SOLO])      target = dbne_pkg::MODE_SOLO;
    else if (now[dbne_pkg::BIT_MUTE]) target = dbne_pkg::MODE_MUTE;
    else if (now[dbne_pkg::BIT_REC])  target = dbne_pkg::MODE_REC;
    else                              target = dbne_pkg::MODE_VPOT;
    if (mode_hit) mode_nxt = (mode_r != target) ? target : dbne_pkg::MODE_SELECT;
    else          mode_nxt = mode_r;
  end

  // Channel note base of the mode in force after this tick
  always_comb begin
    unique case (mode_nxt)
      dbne_pkg::MODE_SOLO: base_sel = base_r[1];
      dbne_pkg::MODE_MUTE: base_sel = base_r[2];
      dbne_pkg::MODE_REC:  base_sel = base_r[3];
      dbne_pkg::MODE_VPOT: base_sel = base_r[4];
      default:             base_sel = base_r[0];
    endcase
  end

  // Results due: mode report, channels, beats, name
  assign slots = stable ? {delta[dbne_pkg::BIT_NAME], delta[dbne_pkg::BIT_BEATS],
                           delta[dbne_pkg::NumChan-1:0], mode_hit}
                        : '0;

  // Build the record, hold it until the serializer takes it
  always_comb begin
    rec_nxt       = rec_r;
    rec_valid_nxt = rec_valid_r;
    if (rec_take) rec_valid_nxt = 1'b0;
    if (in_acc && (|slots)) begin
      rec_valid_nxt   = 1'b1;
      rec_nxt.slots   = slots;
      rec_nxt.buttons = now;
      rec_nxt.mode    = mode_nxt;
      rec_nxt.base    = base_sel;
      rec_nxt.cable   = cable_r;
    end
  end

  // Advance history, stable value and mode on each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEBOUNCE_DEPTH; i++) hist_r[i] <= '0;
      stable_r    <= '0;
      mode_r      <= dbne_pkg::MODE_SELECT;
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      if (in_acc) begin
        for (int i = 0; i < DEBOUNCE_DEPTH - 1; i++) hist_r[i] <= hist_r[i+1];
        hist_r[DEBOUNCE_DEPTH-1] <= now;
        if (stable) stable_r <= now;
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cable_r   <= dbne_pkg::CABLE_RST;
      base_r[0] <= dbne_pkg::SELECT_BASE_RST;
      base_r[1] <= dbne_pkg::SOLO_BASE_RST;
      base_r[2] <= dbne_pkg::MUTE_BASE_RST;
      base_r[3] <= dbne_pkg::REC_BASE_RST;
      base_r[4] <= dbne_pkg::VPOT_BASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dbne_pkg::REG_CABLE:       cable_r   <= cfg_data[dbne_pkg::CableW-1:0];
        dbne_pkg::REG_SELECT_BASE: base_r[0] <= cfg_data[dbne_pkg::NoteW-1:0];
        dbne_pkg::REG_SOLO_BASE:   base_r[1] <= cfg_data[dbne_pkg::NoteW-1:0];
        dbne_pkg::REG_MUTE_BASE:   base_r[2] <= cfg_data[dbne_pkg::NoteW-1:0];
        dbne_pkg::REG_REC_BASE:    base_r[3] <= cfg_data[dbne_pkg::NoteW-1:0];
        dbne_pkg::REG_VPOT_BASE:   base_r[4] <= cfg_data[dbne_pkg::NoteW-1:0];
        default: ;
      endcase
    end
  end

  assign rec       = rec_r;
  assign rec_valid = rec_valid_r;

endmodule

// ===== rtl/dbne_serial.sv =====
module dbne_serial (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dbne_pkg::rec_t               rec,
  input  logic                         rec_valid,
  output logic                         rec_take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_mode_report,
  output logic [dbne_pkg::ModeW-1:0]   out_mode_code,
  output logic [dbne_pkg::NoteW-1:0]   out_note_number,
  output logic [dbne_pkg::VelW-1:0]    out_velocity,
  output logic [dbne_pkg::CableW-1:0]  out_cable,
  output logic                         out_last_of_run
);

  dbne_pkg::rec_t               work_r;
  logic [dbne_pkg::SlotW-1:0]   slots_r;
  logic                         out_valid_r;
  logic                         rep_r, last_r;
  logic [dbne_pkg::ModeW-1:0]   mode_r;
  logic [dbne_pkg::NoteW-1:0]   note_r, note_nxt;
  logic [dbne_pkg::VelW-1:0]    vel_r, vel_nxt;
  logic [dbne_pkg::CableW-1:0]  cable_r, cable_nxt;

  logic                         out_free, pop;
  logic [dbne_pkg::SlotW-1:0]   pick, rest;
  logic [dbne_pkg::NumChan-1:0] chan_pick;
  logic [dbne_pkg::ChanIdxW-1:0] chan_idx;
  logic                         chan_on;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = out_free && (|slots_r);
  assign rest     = slots_r & (slots_r - 1'b1);
  assign pick     = slots_r & ~(slots_r - 1'b1);
  assign rec_take = rec_valid && ((slots_r == '0) || (pop && (rest == '0)));

  // Encode the picked channel and its pressed state
  assign chan_pick = pick[dbne_pkg::SLOT_CHAN0 +: dbne_pkg::NumChan];
  always_comb begin
    chan_idx = '0;
    for (int i = 0; i < dbne_pkg::NumChan; i++) begin
      if (chan_pick[i]) chan_idx = chan_idx | dbne_pkg::ChanIdxW'(i);
    end
  end
  assign chan_on = |(chan_pick & work_r.buttons[dbne_pkg::NumChan-1:0]);

  // Fields of the picked result
  always_comb begin
    note_nxt  = work_r.base + {{(dbne_pkg::NoteW-dbne_pkg::ChanIdxW){1'b0}}, chan_idx};
    vel_nxt   = chan_on ? dbne_pkg::VEL_ON : dbne_pkg::VEL_OFF;
    cable_nxt = work_r.cable;
    if (pick[dbne_pkg::SLOT_REPORT]) begin
      note_nxt  = '0;
      vel_nxt   = dbne_pkg::VEL_OFF;
      cable_nxt = '0;
    end else if (pick[dbne_pkg::SLOT_BEATS]) begin
      note_nxt = dbne_pkg::NOTE_BEATS;
      vel_nxt  = work_r.buttons[dbne_pkg::BIT_BEATS] ? dbne_pkg::VEL_ON : dbne_pkg::VEL_OFF;
    end else if (pick[dbne_pkg::SLOT_NAME]) begin
      note_nxt = dbne_pkg::NOTE_NAME;
      vel_nxt  = work_r.buttons[dbne_pkg::BIT_NAME] ? dbne_pkg::VEL_ON : dbne_pkg::VEL_OFF;
    end
  end

  // Load a new record or drop the slot just emitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rec_take)  slots_r <= rec.slots;
      else if (pop)  slots_r <= rest;
      if (pop)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) work_r <= rec;
    if (pop) begin
      rep_r   <= pick[dbne_pkg::SLOT_REPORT];
      mode_r  <= work_r.mode;
      note_r  <= note_nxt;
      vel_r   <= vel_nxt;
      cable_r <= cable_nxt;
      last_r  <= (rest == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_mode_report = rep_r;
  assign out_mode_code      = mode_r;
  assign out_note_number    = note_r;
  assign out_velocity       = vel_r;
  assign out_cable          = cable_r;
  assign out_last_of_run    = last_r;

endmodule

// ===== rtl/debounced_buttons_to_note_events.sv =====
// Path: the first result of a tick passes the record register, the serializer's slot register and the output register.
// Throughput: one result per cycle from the serializer while out_stall is low; a tick
// that yields no result does not reach the serializer, and while the serializer works
// through a tick's results the next tick is already taken into the record register.
// Reset (rst_n low, synchronous): history, stable value and mode clear; config to defaults.
module debounced_buttons_to_note_events #(
  parameter int unsigned DEBOUNCE_DEPTH = dbne_pkg::DebounceDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dbne_pkg::ButtonW-1:0]  in_pressed_vector,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_mode_report,
  output logic [dbne_pkg::ModeW-1:0]    out_mode_code,
  output logic [dbne_pkg::NoteW-1:0]    out_note_number,
  output logic [dbne_pkg::VelW-1:0]     out_velocity,
  output logic [dbne_pkg::CableW-1:0]   out_cable,
  output logic                          out_last_of_run,
  input  logic                          cfg_wr_en,
  input  logic [dbne_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dbne_pkg::CfgDataW-1:0] cfg_data
);

  dbne_pkg::rec_t rec;
  logic           rec_valid;
  logic           rec_take;

  // Debounce, mode update and record build
  dbne_front #(
    .DEBOUNCE_DEPTH(DEBOUNCE_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pressed_vector (in_pressed_vector),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .rec               (rec),
    .rec_valid         (rec_valid),
    .rec_take          (rec_take)
  );

  // Emit results one per cycle while out_stall is low
  dbne_serial u_serial (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec                (rec),
    .rec_valid          (rec_valid),
    .rec_take           (rec_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_mode_report (out_is_mode_report),
    .out_mode_code      (out_mode_code),
    .out_note_number    (out_note_number),
    .out_velocity       (out_velocity),
    .out_cable          (out_cable),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

// ===== rtl/dbne_checker.sv =====
`include "debounced_buttons_to_note_events_macros.svh"

module dbne_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [dbne_pkg::ButtonW-1:0]  in_pressed_vector,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_is_mode_report,
  input logic [dbne_pkg::ModeW-1:0]    out_mode_code,
  input logic [dbne_pkg::NoteW-1:0]    out_note_number,
  input logic [dbne_pkg::VelW-1:0]     out_velocity,
  input logic [dbne_pkg::CableW-1:0]   out_cable,
  input logic                          out_last_of_run,
  input logic                          cfg_wr_en,
  input logic [dbne_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [dbne_pkg::CfgDataW-1:0] cfg_data
);

  // Hold a stalled result transaction
  `DBNE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_note_number) && $stable(out_velocity) && $stable(out_is_mode_report) && $stable(out_last_of_run), "stalled result changed")

  // Mode reports carry no note, velocity or cable
  `DBNE_ASSERT_IMP(a_report_zero, out_valid && out_is_mode_report, out_note_number == '0 && out_velocity == dbne_pkg::VEL_OFF && out_cable == '0, "mode report with note fields")

  // Velocity is either full on or off
  `DBNE_ASSERT_IMP(a_vel_code, out_valid, out_velocity == dbne_pkg::VEL_ON || out_velocity == dbne_pkg::VEL_OFF, "bad velocity")

  // A run continues without gaps once its result is taken
  `DBNE_ASSERT_NXT(a_run_cont, out_valid && !out_stall && !out_last_of_run, out_valid, "gap inside a run")

endmodule

bind debounced_buttons_to_note_events dbne_checker u_dbne_checker (.*);

// ===== tb/note_event_checker.sv =====
module note_event_checker
  import dbne_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [ButtonW-1:0]  in_pressed_vector,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_is_mode_report,
  input  logic [ModeW-1:0]    out_mode_code,
  input  logic [NoteW-1:0]    out_note_number,
  input  logic [VelW-1:0]     out_velocity,
  input  logic [CableW-1:0]   out_cable,
  input  logic                out_last_of_run,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int unsigned         mismatch_count,
  output int unsigned         events_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               rep;
    logic [ModeW-1:0]   mode;
    logic [NoteW-1:0]   note;
    logic [VelW-1:0]    vel;
    logic [CableW-1:0]  cable;
    logic               last;
  } note_event_t;

  // Shadow of the block state and its registers
  logic [ButtonW-1:0] sample_hist [DebounceDepthDef];
  logic [ButtonW-1:0] settled;
  logic [ModeW-1:0]   cur_mode;
  logic [CableW-1:0]  cable_reg;
  logic [NoteW-1:0]   base_reg [5];

  note_event_t expected_events [$];
  int unsigned fails = 0;

  function automatic note_event_t note_on(input logic [NoteW-1:0] note, input logic pressed);
    note_event_t ev;
    ev.rep   = 1'b0;
    ev.mode  = cur_mode;
    ev.note  = note;
    ev.vel   = pressed ? VEL_ON : VEL_OFF;
    ev.cable = cable_reg;
    ev.last  = 1'b0;
    return ev;
  endfunction

  // Advance the debounce history and queue the events of a stable change
  function automatic void predict_note_events(input logic [ButtonW-1:0] now);
    logic               steady;
    logic [ButtonW-1:0] changed;
    logic [ModeW-1:0]   pick;
    note_event_t        ev;
    note_event_t        run [$];
    steady = 1'b1;
    foreach (sample_hist[i])
      if (sample_hist[i] != now) steady = 1'b0;
    for (int i = 0; i < DebounceDepthDef - 1; i++) sample_hist[i] = sample_hist[i+1];
    sample_hist[DebounceDepthDef-1] = now;
    if (!steady) return;

    changed = settled ^ now;
    settled = now;

    // Toggle the mode by priority when a mode button moved and one is held
    if (changed[BIT_VPOT:BIT_SOLO] != '0 && now[BIT_VPOT:BIT_SOLO] != '0) begin
      if (now[BIT_SOLO]) pick = MODE_SOLO;
      else if (now[BIT_MUTE]) pick = MODE_MUTE;
      else if (now[BIT_REC]) pick = MODE_REC;
      else pick = MODE_VPOT;
      cur_mode = (cur_mode != pick) ? pick : MODE_SELECT;
      ev = '0;
      ev.rep  = 1'b1;
      ev.mode = cur_mode;
      run.push_back(ev);
    end

    for (int c = 0; c < NumChan; c++)
      if (changed[c]) run.push_back(note_on(NoteW'(base_reg[cur_mode] + c), now[c]));
    if (changed[BIT_BEATS]) run.push_back(note_on(NOTE_BEATS, now[BIT_BEATS]));
    if (changed[BIT_NAME]) run.push_back(note_on(NOTE_NAME, now[BIT_NAME]));

    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_events.push_back(run[i]);
  endfunction

  function automatic void check_field(input string what, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : track
    note_event_t want;
    if (!rst_n) begin
      foreach (sample_hist[i]) sample_hist[i] = '0;
      settled   = '0;
      cur_mode  = MODE_SELECT;
      cable_reg = CABLE_RST;
      base_reg[MODE_SELECT] = SELECT_BASE_RST;
      base_reg[MODE_SOLO]   = SOLO_BASE_RST;
      base_reg[MODE_MUTE]   = MUTE_BASE_RST;
      base_reg[MODE_REC]    = REC_BASE_RST;
      base_reg[MODE_VPOT]   = VPOT_BASE_RST;
      expected_events.delete();
    end else begin
      // Mirror register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CABLE:       cable_reg = cfg_data[CableW-1:0];
          REG_SELECT_BASE: base_reg[MODE_SELECT] = cfg_data;
          REG_SOLO_BASE:   base_reg[MODE_SOLO]   = cfg_data;
          REG_MUTE_BASE:   base_reg[MODE_MUTE]   = cfg_data;
          REG_REC_BASE:    base_reg[MODE_REC]    = cfg_data;
          REG_VPOT_BASE:   base_reg[MODE_VPOT]   = cfg_data;
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual rep=%0b mode=%0d note=%0d vel=%0d cable=%0d last=%0b",
                   $time, out_is_mode_report, out_mode_code, out_note_number,
                   out_velocity, out_cable, out_last_of_run);
          fails++;
        end else begin
          want = expected_events.pop_front();
          check_field("is_mode_report", want.rep, out_is_mode_report);
          check_field("mode_code", want.mode, out_mode_code);
          check_field("note_number", want.note, out_note_number);
          check_field("velocity", want.vel, out_velocity);
          check_field("cable", want.cable, out_cable);
          check_field("last_of_run", want.last, out_last_of_run);
        end
      end

      if (in_valid && !in_stall) predict_note_events(in_pressed_vector);
    end
    mismatch_count <= fails;
    events_pending <= expected_events.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dbne_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned PHASE_TICKS = 80;

  // Indexes with no register behind them
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_ORDER [8] = '{
    REG_CABLE, REG_SELECT_BASE, REG_SOLO_BASE, REG_MUTE_BASE,
    REG_REC_BASE, REG_VPOT_BASE, REG_SPARE_A, REG_SPARE_B
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ButtonW-1:0]  in_pressed_vector;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_is_mode_report;
  logic [ModeW-1:0]    out_mode_code;
  logic [NoteW-1:0]    out_note_number;
  logic [VelW-1:0]     out_velocity;
  logic [CableW-1:0]   out_cable;
  logic                out_last_of_run;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned events_pending;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 66;
  int unsigned tick_count = 0;
  logic [ButtonW-1:0] held_vec = '0;

  debounced_buttons_to_note_events uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pressed_vector  (in_pressed_vector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_mode_report (out_is_mode_report),
    .out_mode_code      (out_mode_code),
    .out_note_number    (out_note_number),
    .out_velocity       (out_velocity),
    .out_cable          (out_cable),
    .out_last_of_run    (out_last_of_run),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  note_event_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pressed_vector  (in_pressed_vector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_mode_report (out_is_mode_report),
    .out_mode_code      (out_mode_code),
    .out_note_number    (out_note_number),
    .out_velocity       (out_velocity),
    .out_cable          (out_cable),
    .out_last_of_run    (out_last_of_run),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .events_pending     (events_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Drive one poll tick and hold it until taken
  task automatic send_tick(input logic [ButtonW-1:0] vec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pressed_vector <= vec;
    do @(posedge clk); while (in_stall);
    tick_count++;
  endtask

  task automatic hold_buttons(input logic [ButtonW-1:0] vec, input int unsigned n);
    repeat (n) send_tick(vec);
  endtask

  // Stop sending and wait until every expected result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write all registers, then both unused indexes
  task automatic load_config(input logic [CfgDataW-1:0] cab, sel, solo, mute, rec, vpot);
    logic [CfgDataW-1:0] vals [8];
    vals = '{cab, sel, solo, mute, rec, vpot, CfgDataW'($urandom), CfgDataW'($urandom)};
    foreach (vals[i]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Mix of debounced presses, bounces and noise
  task automatic random_phase();
    int unsigned start;
    int unsigned kind;
    logic [ButtonW-1:0] nxt;
    start = tick_count;
    while (tick_count - start < PHASE_TICKS) begin
      kind = $urandom_range(19);
      if (kind == 0) begin
        send_tick(ButtonW'($urandom));
      end else if (kind <= 2) begin
        hold_buttons(ButtonW'($urandom), $urandom_range(1, 4));
      end else if (kind == 3) begin
        drain();
      end else begin
        case ($urandom_range(3))
          0: nxt = ButtonW'($urandom);
          1: nxt = held_vec ^ (ButtonW'(1) << $urandom_range(ButtonW - 1));
          2: nxt = held_vec ^ (ButtonW'($urandom_range(15)) << BIT_SOLO);
          default: nxt = held_vec ^ (ButtonW'($urandom) & ButtonW'($urandom));
        endcase
        held_vec = nxt;
        hold_buttons(nxt, $urandom_range(5, 7));
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_pressed_vector <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_CABLE;
    cfg_data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset configuration
    hold_buttons(14'h0000, 1);  // stable, no change
    hold_buttons(14'h3FFF, 5);  // everything pressed: report plus ten notes
    hold_buttons(14'h0000, 5);  // everything released, no mode held
    hold_buttons(14'h0001, 1);  // bounce on channel 0
    hold_buttons(14'h0000, 1);
    hold_buttons(14'h0001, 2);
    hold_buttons(14'h0300, 5);  // solo and mute together: solo wins
    hold_buttons(14'h0200, 5);  // solo released while mute held
    hold_buttons(14'h0CFF, 5);  // rec over vpot, channels in rec mode
    hold_buttons(14'h1800, 5);  // rec released under vpot, beats pressed
    hold_buttons(14'h2800, 5);  // name pressed, beats released, mode unchanged
    hold_buttons(14'h0000, 5);
    hold_buttons(14'h0800, 5);  // vpot again while active: back to select
    drain();

    // Random phases, each with its own register setting
    load_config(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
    random_phase();
    drain();

    send_idle_pct = 66;
    recv_idle_pct = 8;
    load_config('1, '1, '1, '1, '1, '1);  // cable masked, channel notes wrap
    hold_buttons(14'h00FF, 5);
    random_phase();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config('0, '0, '0, '0, '0, '0);
    random_phase();
    drain();

    if (mismatch_count == 0 && events_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
